// ===== rtl/qas_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the quiet area shortener.
// Used by every module of the block; depends on nothing.
package qas_pkg;

    localparam int POS_BITS   = 32;
    localparam int COUNT_BITS = 20;
    localparam int OUT_W      = 32;
    localparam int KF_W       = 17;
    localparam int PROD_W     = POS_BITS + 1 + KF_W;
    localparam int FRAC_SHIFT = 16;

    // Area request queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [POS_BITS-1:0]   POS_MAX    = {POS_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_MAX    = {COUNT_BITS{1'b1}};
    localparam logic [KF_W-1:0]       KF_ONE     = KF_W'(1 << FRAC_SHIFT);
    localparam logic [PROD_W-1:0]     ROUND_HALF = PROD_W'(1 << (FRAC_SHIFT - 1));

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_QUIET_THRESHOLD = 3'd0,
        REG_QUIET_SAMPLES   = 3'd1,
        REG_UNQUIET_SAMPLES = 3'd2,
        REG_KEEP_FRACTION   = 3'd3,
        REG_MIN_CROSSFADE   = 3'd4
    } reg_idx_t;

    // Quiet detection modes
    typedef enum logic [1:0] {
        MODE_WAIT  = 2'd0,
        MODE_CHECK = 2'd1,
        MODE_AREA  = 2'd2,
        MODE_CLOSE = 2'd3
    } mode_t;

    typedef struct packed {
        logic [15:0] quiet_threshold;
        logic [19:0] quiet_samples;
        logic [19:0] unquiet_samples;
        logic [16:0] keep_fraction;
        logic [15:0] min_crossfade;
    } cfg_t;

    // One finished area, as handed from front to back
    typedef struct packed {
        logic [POS_BITS-1:0]   area_begin;
        logic [POS_BITS:0]     len;
        logic [COUNT_BITS-1:0] ucount;
        logic                  at_end;
        logic                  fresh;   // first area since reset or last sample
        logic                  ok;      // area longer than one sample
    } area_req_t;

endpackage

// ===== rtl/qas_front.sv =====
`timescale 1ns / 1ps
// Front part: quiet/loud classification, mode machine and area bookkeeping.
// Depends on qas_pkg; pushes one area request per finished area.
module qas_front import qas_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  cfg_t            cfg,
    input  logic            accept,
    input  logic [15:0]     level,
    input  logic            last,
    output logic            push,
    output area_req_t       req
);

    mode_t                 mode_reg, mode_next, mode_step;
    logic [COUNT_BITS-1:0] qc_reg, qc_next;
    logic [COUNT_BITS-1:0] uc_reg, uc_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic [POS_BITS-1:0]   begin_reg, begin_next;
    logic [POS_BITS-1:0]   end_reg, end_next;
    logic                  fresh_reg, fresh_next;

    logic                  quiet;
    logic [19:0]           qt;
    logic                  qc_done, uc_done;
    logic                  close_emit, flush;
    logic [POS_BITS-1:0]   end_pos;

    assign quiet   = level <= cfg.quiet_threshold;
    assign qt      = (cfg.quiet_samples == '0) ? 20'd1 : cfg.quiet_samples;
    assign qc_done = 32'(qc_reg) >= 32'(qt);
    assign uc_done = 32'(uc_reg) >= 32'(cfg.unquiet_samples);

    // Next mode
    always_comb begin
        mode_step = mode_reg;
        case (mode_reg)
            MODE_WAIT:  if (quiet) mode_step = MODE_CHECK;
            MODE_CHECK: begin
                if (!quiet) mode_step = MODE_WAIT;
                else if (qc_done) mode_step = MODE_AREA;
            end
            MODE_AREA:  if (!quiet) mode_step = MODE_CLOSE;
            MODE_CLOSE: begin
                if (quiet) mode_step = MODE_AREA;
                else if (uc_done) mode_step = MODE_WAIT;
            end
            default:    mode_step = MODE_WAIT;
        endcase
        mode_next = mode_reg;
        if (accept) begin
            mode_next = last ? MODE_WAIT : mode_step;
        end
    end

    // Counters, positions and area requests
    always_comb begin
        qc_next    = qc_reg;
        uc_next    = uc_reg;
        pos_next   = pos_reg;
        begin_next = begin_reg;
        end_next   = end_reg;
        fresh_next = fresh_reg;
        close_emit = 1'b0;
        case (mode_reg)
            MODE_WAIT: begin
                if (quiet) begin
                    qc_next    = '0;
                    begin_next = pos_reg;
                end
            end
            MODE_CHECK: begin
                if (quiet && !qc_done && qc_reg < CNT_MAX) qc_next = qc_reg + 1'b1;
            end
            MODE_AREA: begin
                if (!quiet) begin
                    uc_next  = '0;
                    end_next = pos_reg;
                end
            end
            MODE_CLOSE: begin
                if (!quiet && uc_done) close_emit = 1'b1;
                else if (!quiet && uc_reg < CNT_MAX) uc_next = uc_reg + 1'b1;
            end
            default: ;
        endcase
        flush   = last && mode_step == MODE_AREA;
        push    = accept && (close_emit || flush);
        end_pos = flush ? pos_reg : end_reg;

        if (push) fresh_next = 1'b0;
        if (last) begin
            qc_next    = '0;
            uc_next    = '0;
            pos_next   = '0;
            begin_next = '0;
            end_next   = '0;
            fresh_next = 1'b1;
        end else if (pos_reg < POS_MAX) begin
            pos_next = pos_reg + 1'b1;
        end

        req.area_begin = begin_reg;
        req.len        = {1'b0, end_pos} - {1'b0, begin_reg} + 1'b1;
        req.ucount     = flush ? '0 : uc_reg;
        req.at_end     = flush;
        req.fresh      = fresh_reg;
        req.ok         = end_pos > begin_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_WAIT;
            qc_reg    <= '0;
            uc_reg    <= '0;
            pos_reg   <= '0;
            begin_reg <= '0;
            end_reg   <= '0;
            fresh_reg <= 1'b1;
        end else begin
            mode_reg <= mode_next;
            if (accept) begin
                qc_reg    <= qc_next;
                uc_reg    <= uc_next;
                pos_reg   <= pos_next;
                begin_reg <= begin_next;
                end_reg   <= end_next;
                fresh_reg <= fresh_next;
            end
        end
    end

endmodule

// ===== rtl/qas_queue.sv =====
`timescale 1ns / 1ps
// Short queue of area requests between the front and back parts.
// Depends on qas_pkg for the entry type and depth.
module qas_queue import qas_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  area_req_t  push_data,
    input  logic       pop,
    output area_req_t  head,
    output logic       empty,
    output logic       full
);

    area_req_t            entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    assign empty = count_reg == '0;
    assign full  = count_reg == Q_CNT_W'(Q_DEPTH);
    assign head  = entry_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (!push && pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_data;
    end

    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !full || pop)
        else $error("queue written while full");
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !empty)
        else $error("queue read while empty");

endmodule

// ===== rtl/qas_back.sv =====
`timescale 1ns / 1ps
// Back part: turns area requests into delete descriptors in four stages.
// Depends on qas_pkg; owns the running removed-sample total.
module qas_back import qas_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  area_req_t         head,
    input  logic              empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [OUT_W-1:0]  out_src_pos,
    output logic [OUT_W-1:0]  out_dest_pos,
    output logic [OUT_W-1:0]  out_length,
    output logic [OUT_W-1:0]  out_crossfade,
    output logic              out_at_end
);

    logic                  en;

    // Stage 1: product
    logic                  p1_v_reg;
    area_req_t             p1_req_reg;
    logic [PROD_W-1:0]     p1_prod_reg;
    // Stage 2: rounded delete length
    logic                  p2_v_reg;
    area_req_t             p2_req_reg;
    logic [POS_BITS:0]     p2_del_reg;
    // Stage 3: half of kept span, removed total before this area
    logic                  p3_v_reg;
    area_req_t             p3_req_reg;
    logic [POS_BITS:0]     p3_del_reg;
    logic [POS_BITS-1:0]   p3_half_reg;
    logic [POS_BITS-1:0]   p3_base_reg;
    logic [19:0]           p3_lim_reg;

    logic [POS_BITS-1:0]   rt_reg, rt_next;

    logic                  m_valid_reg;
    logic [POS_BITS-1:0]   spos_reg, dpos_reg, xf_reg;
    logic [POS_BITS:0]     del_out_reg;
    logic                  at_end_reg;

    logic [KF_W-1:0]       frac;
    logic                  kf_off;
    area_req_t             pop_req;
    logic [PROD_W-1:0]     prod_rnd;
    logic [POS_BITS:0]     kept;
    logic [POS_BITS-1:0]   base;
    logic [19:0]           qt, uc_ext, lim_min, lim;
    logic [POS_BITS-1:0]   spos, dpos, xf;

    // Hold every stage while the output register waits
    assign en  = !m_valid_reg || out_ready;
    assign pop = en && !empty;

    assign kf_off = cfg.keep_fraction >= KF_ONE;
    assign frac   = kf_off ? '0 : KF_ONE - cfg.keep_fraction;

    // Drop the area when shortening is off
    always_comb begin
        pop_req    = head;
        pop_req.ok = head.ok && !kf_off;
    end

    assign prod_rnd = p1_prod_reg + ROUND_HALF;

    // Kept span, removed total and crossfade limit
    always_comb begin
        kept    = p2_req_reg.len - p2_del_reg;
        base    = p2_req_reg.fresh ? '0 : rt_reg;
        rt_next = rt_reg;
        if (en && p2_v_reg) begin
            rt_next = p2_req_reg.ok ? base + p2_del_reg[POS_BITS-1:0] : base;
        end
        qt      = (cfg.quiet_samples == '0) ? 20'd1 : cfg.quiet_samples;
        uc_ext  = 20'(p2_req_reg.ucount);
        lim_min = (uc_ext < qt) ? uc_ext : qt;
        lim     = (lim_min > 20'(cfg.min_crossfade)) ? lim_min : 20'(cfg.min_crossfade);
    end

    // Final positions and crossfade
    always_comb begin
        spos = p3_req_reg.area_begin + p3_half_reg;
        dpos = p3_req_reg.area_begin - p3_base_reg + p3_half_reg;
        xf   = (spos < POS_BITS'(p3_lim_reg)) ? spos : POS_BITS'(p3_lim_reg);
    end

    // Valid chain and removed total
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg    <= 1'b0;
            p2_v_reg    <= 1'b0;
            p3_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            rt_reg      <= '0;
        end else begin
            rt_reg <= rt_next;
            if (en) begin
                p1_v_reg    <= pop;
                p2_v_reg    <= p1_v_reg;
                p3_v_reg    <= p2_v_reg;
                m_valid_reg <= p3_v_reg && p3_req_reg.ok;
            end
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            p1_req_reg     <= pop_req;
            p1_prod_reg    <= PROD_W'(head.len) * PROD_W'(frac);
            p2_req_reg     <= p1_req_reg;
            p2_del_reg     <= (POS_BITS + 1)'(prod_rnd >> FRAC_SHIFT);
            p3_req_reg     <= p2_req_reg;
            p3_del_reg     <= p2_del_reg;
            p3_half_reg    <= POS_BITS'(kept >> 1);
            p3_base_reg    <= base;
            p3_lim_reg     <= lim;
            spos_reg       <= spos;
            dpos_reg       <= dpos;
            xf_reg         <= xf;
            del_out_reg    <= p3_del_reg;
            at_end_reg     <= p3_req_reg.at_end;
        end
    end

    assign out_valid     = m_valid_reg;
    assign out_src_pos   = OUT_W'(spos_reg);
    assign out_dest_pos  = OUT_W'(dpos_reg);
    assign out_length    = OUT_W'(del_out_reg);
    assign out_crossfade = OUT_W'(xf_reg);
    assign out_at_end    = at_end_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !out_ready) |=> $stable(p3_v_reg) && $stable(rt_reg))
        else $error("back pipeline moved while output stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (en && p2_v_reg && p2_req_reg.fresh && !p2_req_reg.ok) |=> rt_reg == '0)
        else $error("removed total not cleared on first area of a run");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> xf_reg <= spos_reg)
        else $error("crossfade longer than source position");

endmodule

// ===== rtl/quiet_area_shortener_core.sv =====
`timescale 1ns / 1ps
// Top level of the quiet area shortener: configuration registers, front,
// queue and back. Depends on qas_pkg, qas_front, qas_queue and qas_back.
//
// Channel  | Direction | Content
// s_       | in        | s_tdata[15:0] level, s_tlast last sample of selection
// m_       | out       | m_tdata spos/dpos/length/crossfade, m_tuser at_end
// apb      | in/out    | five registers at byte addresses 0,4,8,12,16
//
// One sample is taken every cycle; s_tready only drops when four area requests
// are queued behind a stalled m_ channel. A descriptor becomes valid once the
// area request of its closing sample has passed the queue, the multiplier,
// rounding and position stages, then the output register. Reset is synchronous,
// active low, and clears all area state; registers return to their defaults.
module quiet_area_shortener_core import qas_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // Input samples
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,     // [15:0] level
    input  logic         s_tlast,
    // Delete descriptors
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,     // [31:0] delete_src_pos, [63:32] delete_dest_pos,
                                      // [95:64] delete_length, [127:96] crossfade_length
    output logic [0:0]   m_tuser,     // [0] at_end
    // Configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    cfg_t       cfg_reg;
    logic       cfg_wr;
    reg_idx_t   reg_idx;
    logic       accept;
    logic       push, pop, q_empty, q_full;
    area_req_t  req, head;
    logic       at_end;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[4:2]);

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.quiet_threshold <= 16'd655;
            cfg_reg.quiet_samples   <= 20'd4410;
            cfg_reg.unquiet_samples <= 20'd4410;
            cfg_reg.keep_fraction   <= 17'd32768;
            cfg_reg.min_crossfade   <= 16'd44;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_QUIET_THRESHOLD: cfg_reg.quiet_threshold <= pwdata[15:0];
                REG_QUIET_SAMPLES:   cfg_reg.quiet_samples   <= pwdata[19:0];
                REG_UNQUIET_SAMPLES: cfg_reg.unquiet_samples <= pwdata[19:0];
                REG_KEEP_FRACTION:   cfg_reg.keep_fraction   <= pwdata[16:0];
                REG_MIN_CROSSFADE:   cfg_reg.min_crossfade   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_QUIET_THRESHOLD: prdata = 32'(cfg_reg.quiet_threshold);
            REG_QUIET_SAMPLES:   prdata = 32'(cfg_reg.quiet_samples);
            REG_UNQUIET_SAMPLES: prdata = 32'(cfg_reg.unquiet_samples);
            REG_KEEP_FRACTION:   prdata = 32'(cfg_reg.keep_fraction);
            REG_MIN_CROSSFADE:   prdata = 32'(cfg_reg.min_crossfade);
            default:             prdata = '0;
        endcase
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    qas_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .accept  (accept),
        .level   (s_tdata),
        .last    (s_tlast),
        .push    (push),
        .req     (req)
    );

    qas_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (req),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    qas_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .head          (head),
        .empty         (q_empty),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_src_pos   (m_tdata[31:0]),
        .out_dest_pos  (m_tdata[63:32]),
        .out_length    (m_tdata[95:64]),
        .out_crossfade (m_tdata[127:96]),
        .out_at_end    (at_end)
    );

    assign m_tuser = at_end;

endmodule

// ===== tb/quiet_area_shortener_core_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the quiet area shortener: follows register writes and input items,
// predicts delete descriptors and compares them with the m_ channel. Depends on qas_pkg.
module quiet_area_shortener_core_checker import qas_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [15:0]  s_tdata,     // [15:0] level
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,     // [31:0] src_pos, [63:32] dest_pos,
                                      // [95:64] length, [127:96] crossfade
    input  logic [0:0]   m_tuser,     // [0] at_end
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    input  logic         end_of_run,
    output int           deletes_pending,
    output int           mismatches
);

    typedef struct packed {
        logic [31:0] src_pos;
        logic [31:0] dest_pos;
        logic [31:0] length;
        logic [31:0] xfade;
        logic        at_end;
    } delete_desc_t;

    // Register copies
    logic [15:0] thr_reg;
    logic [19:0] qs_reg;
    logic [19:0] unq_reg;
    logic [16:0] kf_reg;
    logic [15:0] xf_min_reg;

    // Area tracking state
    mode_t       mode;
    logic [19:0] quiet_cnt;
    logic [19:0] unquiet_cnt;
    logic [31:0] pos;
    logic [31:0] area_begin;
    logic [31:0] area_end;
    logic [31:0] removed;

    delete_desc_t pending_deletes[$];
    int           mismatch_total = 0;
    bit           end_checked = 0;

    function automatic void clear_area();
        mode        = MODE_WAIT;
        quiet_cnt   = '0;
        unquiet_cnt = '0;
        pos         = '0;
        area_begin  = '0;
        area_end    = '0;
        removed     = '0;
    endfunction

    // Build the descriptor of a finished area; returns 1 if one is due
    function automatic bit close_area(input logic [19:0] ucount, input bit flush,
                                      output delete_desc_t d);
        logic [63:0] len, del, half, qt, xf;
        logic [31:0] sp, dp;
        d = '0;
        if (kf_reg >= KF_ONE || area_end < area_begin)
            return 0;
        len = 64'(area_end) - 64'(area_begin) + 64'd1;
        if (len <= 64'd1)
            return 0;
        del  = (len * (64'(KF_ONE) - 64'(kf_reg)) + 64'd32768) >> 16;
        half = (len - del) / 64'd2;
        sp   = area_begin + half[31:0];
        dp   = area_begin - removed + half[31:0];
        qt   = (qs_reg == '0) ? 64'd1 : 64'(qs_reg);
        xf   = (64'(ucount) < qt) ? 64'(ucount) : qt;
        if (64'(xf_min_reg) > xf)
            xf = 64'(xf_min_reg);
        if (64'(sp) < xf)
            xf = 64'(sp);
        removed    = removed + del[31:0];
        d.src_pos  = sp;
        d.dest_pos = dp;
        d.length   = del[31:0];
        d.xfade    = xf[31:0];
        d.at_end   = flush;
        return 1;
    endfunction

    // Advance the area machine by one sample
    function automatic bit shorten_sample(input logic [15:0] lvl, input bit lst,
                                          output delete_desc_t d);
        bit          quiet;
        bit          got;
        logic [19:0] qt;
        quiet = (lvl <= thr_reg);
        qt    = (qs_reg == '0) ? 20'd1 : qs_reg;
        got   = 0;
        d     = '0;
        case (mode)
            MODE_WAIT: begin
                if (quiet) begin
                    mode       = MODE_CHECK;
                    quiet_cnt  = '0;
                    area_begin = pos;
                end
            end
            MODE_CHECK: begin
                if (!quiet)
                    mode = MODE_WAIT;
                else if (quiet_cnt >= qt)
                    mode = MODE_AREA;
                else if (quiet_cnt != CNT_MAX)
                    quiet_cnt = quiet_cnt + 20'd1;
            end
            MODE_AREA: begin
                if (!quiet) begin
                    mode        = MODE_CLOSE;
                    unquiet_cnt = '0;
                    area_end    = pos;
                end
            end
            default: begin
                if (quiet) begin
                    mode = MODE_AREA;
                end else if (unquiet_cnt >= unq_reg) begin
                    mode = MODE_WAIT;
                    got  = close_area(unquiet_cnt, 1'b0, d);
                end else if (unquiet_cnt != CNT_MAX) begin
                    unquiet_cnt = unquiet_cnt + 20'd1;
                end
            end
        endcase
        // Flush an open area on the last sample, then start over
        if (lst) begin
            if (mode == MODE_AREA) begin
                area_end = pos;
                got      = close_area('0, 1'b1, d);
            end
            clear_area();
        end else if (pos != POS_MAX[31:0]) begin
            pos = pos + 32'd1;
        end
        return got;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, seen);
            mismatch_total++;
        end
    endtask

    always @(posedge aclk) begin : watch
        delete_desc_t want;
        delete_desc_t fresh;
        if (!aresetn) begin
            thr_reg    = 16'd655;
            qs_reg     = 20'd4410;
            unq_reg    = 20'd4410;
            kf_reg     = 17'd32768;
            xf_min_reg = 16'd44;
            clear_area();
            pending_deletes.delete();
        end else begin
            // Follow register writes
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_QUIET_THRESHOLD: thr_reg    = pwdata[15:0];
                    REG_QUIET_SAMPLES:   qs_reg     = pwdata[19:0];
                    REG_UNQUIET_SAMPLES: unq_reg    = pwdata[19:0];
                    REG_KEEP_FRACTION:   kf_reg     = pwdata[16:0];
                    REG_MIN_CROSSFADE:   xf_min_reg = pwdata[15:0];
                    default: ;
                endcase
            end
            // Compare a delivered descriptor with the oldest prediction
            if (m_tvalid && m_tready) begin
                if (pending_deletes.size() == 0) begin
                    $error("unexpected delete descriptor: src_pos %0d length %0d",
                           m_tdata[31:0], m_tdata[95:64]);
                    mismatch_total++;
                end else begin
                    want = pending_deletes.pop_front();
                    check_field("delete_src_pos", want.src_pos, m_tdata[31:0]);
                    check_field("delete_dest_pos", want.dest_pos, m_tdata[63:32]);
                    check_field("delete_length", want.length, m_tdata[95:64]);
                    check_field("crossfade_length", want.xfade, m_tdata[127:96]);
                    check_field("at_end", 32'(want.at_end), 32'(m_tuser[0]));
                end
            end
            // Predict from each accepted item
            if (s_tvalid && s_tready) begin
                if (shorten_sample(s_tdata, s_tlast, fresh))
                    pending_deletes.push_back(fresh);
            end
            // Anything still waiting at the end never arrived
            if (end_of_run && !end_checked) begin
                end_checked = 1;
                if (pending_deletes.size() != 0) begin
                    $error("%0d delete descriptors never arrived", pending_deletes.size());
                    mismatch_total += pending_deletes.size();
                end
            end
        end
        deletes_pending <= pending_deletes.size();
        mismatches      <= mismatch_total;
    end

endmodule

// ===== tb/quiet_area_shortener_core_test.sv =====
`timescale 1ns / 1ps
// Regression top for the quiet area shortener: clock, reset, register writes,
// level stimulus and output backpressure. Depends on qas_pkg, the core and the checker.
module quiet_area_shortener_core_test import qas_pkg::*; ();

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [15:0]  s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         end_of_run;
    int           deletes_pending;
    int           mismatches;

    // Stimulus knobs
    int cur_thr = 655;
    int cur_qs  = 4410;
    int cur_unq = 4410;
    int samples_sent = 0;
    int hold_token = 0;
    bit calm = 0;
    bit idle_on = 1;

    quiet_area_shortener_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    quiet_area_shortener_core_checker scoreboard (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .end_of_run(end_of_run),
        .deletes_pending(deletes_pending), .mismatches(mismatches)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Abort when nothing moves for too long
    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("quiet_area_shortener_core regression: fail");
                $finish;
            end
        end
    end

    // Result side: random bursts of backpressure plus one long hold-off on request
    initial begin : receiver
        int hold_seen;
        int rx_steps;
        bit rx_idle_on;
        hold_seen  = 0;
        rx_steps   = 0;
        rx_idle_on = 1;
        m_tready   = 1'b0;
        forever begin
            rx_steps++;
            if (rx_steps % 64 == 0)
                rx_idle_on = ($urandom_range(0, 3) != 0);
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!calm && rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    function automatic logic [15:0] pick_level(input bit quiet);
        if (quiet || cur_thr == 65535)
            return 16'($urandom_range(0, cur_thr));
        return 16'($urandom_range(cur_thr + 1, 65535));
    endfunction

    // Offer one item and hold it until accepted
    task automatic send_level(input logic [15:0] lvl, input bit lst);
        if (samples_sent % 64 == 0)
            idle_on = ($urandom_range(0, 3) != 0);
        if (!calm && idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= lvl;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        samples_sent++;
    endtask

    task automatic send_run(input bit quiet, input int n, input bit end_last);
        for (int i = 0; i < n; i++)
            send_level(pick_level(quiet), end_last && (i == n - 1));
    endtask

    // Loud lead-in, quiet run, loud run unless selection ends; runs near limits up to 40
    task automatic send_area(input int last_odds);
        int qt, qlen, ulen, cut, ending;
        qt = (cur_qs == 0) ? 1 : cur_qs;
        if (qt > 40)
            qlen = $urandom_range(1, 40);
        else
            qlen = qt - 1 + int'($urandom_range(0, 6));
        if (qlen < 1)
            qlen = 1;
        if (cur_unq > 40)
            ulen = $urandom_range(1, 40);
        else
            ulen = cur_unq - 1 + int'($urandom_range(0, 5));
        if (ulen < 1)
            ulen = 1;
        ending = $urandom_range(0, last_odds);
        send_run(1'b0, $urandom_range(1, 3), 1'b0);
        if (ending == 0) begin
            // end the selection inside the quiet run
            send_run(1'b1, qlen, 1'b1);
        end else begin
            send_run(1'b1, qlen, 1'b0);
            // break the loud run with a single quiet sample now and then
            if (ulen > 2 && $urandom_range(0, 3) == 0) begin
                cut = $urandom_range(1, ulen - 1);
                send_run(1'b0, cut, 1'b0);
                send_run(1'b1, 1, 1'b0);
                ulen -= cut;
            end
            send_run(1'b0, ulen, ending == 1);
        end
    endtask

    // Wait until every predicted descriptor is out and the pipeline is empty
    task automatic settle();
        repeat (2) @(posedge aclk);
        while (deletes_pending != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
    endtask

    task automatic set_config(input int thr, input int qs, input int unq,
                              input int kf, input int mxf);
        write_reg(REG_QUIET_THRESHOLD, 32'(thr));
        write_reg(REG_QUIET_SAMPLES, 32'(qs));
        write_reg(REG_UNQUIET_SAMPLES, 32'(unq));
        write_reg(REG_KEEP_FRACTION, 32'(kf));
        write_reg(REG_MIN_CROSSFADE, 32'(mxf));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_thr = thr;
        cur_qs  = qs;
        cur_unq = unq;
    endtask

    // One random phase under one register setting, closed by a last sample
    task automatic run_phase(input int thr, input int qs, input int unq, input int kf,
                             input int mxf, input int n_items, input int last_odds,
                             input bit squeeze);
        int stop_at;
        settle();
        set_config(thr, qs, unq, kf, mxf);
        if (squeeze)
            hold_token++;
        stop_at = samples_sent + n_items;
        while (samples_sent < stop_at) begin
            if ($urandom_range(0, 9) < 7) begin
                send_area(last_odds);
            end else begin
                repeat ($urandom_range(1, 8))
                    send_level(16'($urandom_range(0, 65535)), $urandom_range(0, 19) == 0);
            end
        end
        send_level(pick_level($urandom_range(0, 1)), 1'b1);
        s_tvalid <= 1'b0;
    endtask

    initial begin : stimulus
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        end_of_run = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: only level 0 is quiet, delete the whole area, huge crossfade floor
        settle();
        set_config(0, 1, 0, 0, 65535);
        send_level(16'hFFFF, 1'b0);
        repeat (4) send_level(16'h0000, 1'b0);
        send_level(16'hFFFF, 1'b0);
        send_level(16'hFFFF, 1'b0);
        repeat (3) send_level(16'h0000, 1'b0);
        send_level(16'h0000, 1'b1);              // open area flushed at the end
        s_tvalid <= 1'b0;

        // Directed: zero-length delete, quiet_samples of zero, last while closing
        settle();
        set_config(65534, 0, 1, 65535, 0);
        send_level(16'hFFFF, 1'b0);
        send_level(16'd100, 1'b0);
        send_level(16'd200, 1'b0);
        send_level(16'd300, 1'b0);
        repeat (3) send_level(16'hFFFF, 1'b0);
        send_level(16'd1, 1'b0);
        send_level(16'd2, 1'b0);
        send_level(16'd3, 1'b0);
        send_level(16'hFFFF, 1'b0);
        send_level(16'hFFFF, 1'b1);              // last sample while closing: no result
        s_tvalid <= 1'b0;

        // Random phases
        run_phase($urandom_range(1000, 60000), $urandom_range(1, 6), $urandom_range(0, 5),
                  $urandom_range(0, 65535), $urandom_range(0, 8), 250, 8, 1'b0);
        run_phase(30000, 1, 0, 16384, 2, 200, 12, 1'b1);
        run_phase(65535, 2, 3, 40000, 65535, 80, 3, 1'b0);
        run_phase($urandom_range(0, 65535), $urandom_range(1, 4), $urandom_range(0, 3),
                  65536, $urandom_range(0, 65535), 80, 6, 1'b0);
        run_phase($urandom_range(0, 65535), $urandom_range(1, 4), $urandom_range(0, 3),
                  131071, $urandom_range(0, 65535), 60, 6, 1'b0);
        run_phase($urandom_range(1, 65534), 1048575, 1048575, $urandom_range(0, 65535),
                  $urandom_range(0, 100), 60, 6, 1'b0);
        run_phase($urandom_range(1, 65534), 0, 0, $urandom_range(0, 65535), 0,
                  200, 8, 1'b0);
        run_phase($urandom_range(1, 65534), $urandom_range(1, 10), $urandom_range(0, 8),
                  $urandom_range(0, 65535), $urandom_range(0, 12), 250, 8, 1'b0);
        calm = 1;
        run_phase($urandom_range(1, 65534), $urandom_range(1, 5), $urandom_range(0, 4),
                  $urandom_range(0, 65535), $urandom_range(0, 6), 200, 8, 1'b0);

        // Drain and give the verdict
        settle();
        end_of_run <= 1'b1;
        repeat (3) @(posedge aclk);
        if (mismatches == 0)
            $display("quiet_area_shortener_core regression: pass");
        else
            $display("quiet_area_shortener_core regression: fail");
        $finish;
    end

endmodule
